[design/battery_power_monitor_limiter_core_macros.svh]
// Assertion macros shared by the battery power monitor and limiter RTL.
`ifndef BATTERY_POWER_MONITOR_LIMITER_CORE_MACROS_SVH
`define BATTERY_POWER_MONITOR_LIMITER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define BPML_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpml: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset
`define BPML_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpml: next-cycle check failed");

`endif

[design/bpml_pkg.sv]
// Types and constants for the battery power monitor and limiter.
`timescale 1ns / 1ps
`default_nettype none

package bpml_pkg;

   // field widths
   localparam int VOLT_DV_W  = 14;
   localparam int CUR_MA_W   = 21;
   localparam int CHARGE_W   = 7;
   localparam int TEMP_W     = 9;
   localparam int VOLT_W     = 10;
   localparam int CUR_A_W    = 11;
   localparam int POWER_W    = 11;
   localparam int PEAK_W     = 10;
   localparam int PROD_W     = 21;
   localparam int RND_W      = 20;
   localparam int LIM_W      = 24;
   localparam int MAXW_W     = 20;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_POWER   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHARGE_LOW  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHARGE_CRIT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEMP_HIGH   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TEMP_CRIT   = 3'd4;

   // register reset values
   localparam logic [9:0]        MAX_POWER_RST   = 10'd80;
   localparam logic [MAXW_W-1:0] MAX_POWER_W_RST = 20'd80000;
   localparam logic [6:0]        CHARGE_LOW_RST  = 7'd30;
   localparam logic [6:0]        CHARGE_CRIT_RST = 7'd20;
   localparam logic [8:0]        TEMP_HIGH_RST   = 9'd50;
   localparam logic [8:0]        TEMP_CRIT_RST   = 9'd60;

   // unit scaling
   localparam int DV_PER_V   = 10;
   localparam int MA_PER_A   = 1000;
   localparam int W_PER_KW   = 1000;
   localparam logic [RND_W-1:0]   ROUND_HALF = 20'd500;
   localparam logic [VOLT_W-1:0]  VOLT_MAX   = 10'd1000;
   localparam logic [CUR_A_W-1:0] CUR_MAX    = 11'd1000;

   // input register
   typedef struct packed {
      logic [VOLT_DV_W-1:0] volt_dv;
      logic [CUR_MA_W-1:0]  cur_ma;
      logic [CHARGE_W-1:0]  charge;
      logic [TEMP_W-1:0]    temp;
   } s1_type;

   // whole units plus derating
   typedef struct packed {
      logic [VOLT_W-1:0]  volt;
      logic [CUR_A_W-1:0] cur;
      logic               zeroed;
      logic [1:0]         shift;
   } s2_type;

   // raw V*A product
   typedef struct packed {
      logic [VOLT_W-1:0]  volt;
      logic [CUR_A_W-1:0] cur;
      logic [PROD_W-1:0]  prod;
      logic               zeroed;
      logic [1:0]         shift;
   } s3_type;

   // rounded power and limit flag
   typedef struct packed {
      logic [VOLT_W-1:0]  volt;
      logic [CUR_A_W-1:0] cur;
      logic [POWER_W-1:0] power;
      logic               limit;
   } s4_type;

   // ring stage carry
   typedef struct packed {
      logic [VOLT_W-1:0]  volt;
      logic [POWER_W-1:0] power;
      logic               limit;
   } s5_type;

   // result word
   typedef struct packed {
      logic               limit;
      logic               over;
      logic [PEAK_W-1:0]  peak_cur;
      logic [PEAK_W-1:0]  peak_volt;
      logic [PEAK_W-1:0]  peak_power;
      logic [POWER_W-1:0] avg;
      logic [POWER_W-1:0] power;
      logic [VOLT_W-1:0]  volt;
   } rsp_type;

endpackage

`default_nettype wire

[design/bpml_div_const.sv]
// Unsigned divide by a constant through a reciprocal multiply, exact over the input range.
`timescale 1ns / 1ps
`default_nettype none

module bpml_div_const #(
   parameter int WIDTH   = 14,
   parameter int DIVISOR = 10
) (
   input  logic [WIDTH-1:0] dividend,
   output logic [WIDTH-1:0] quotient
);

   // shift large enough that the reciprocal error stays below one step
   localparam int SHIFT = WIDTH + $clog2(DIVISOR) + 1;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int MUL_W = WIDTH + SHIFT + 1;

   logic [SHIFT:0]   recip_w;
   logic [MUL_W-1:0] mul;

   assign recip_w  = RECIP[SHIFT:0];
   assign mul      = MUL_W'(dividend) * MUL_W'(recip_w);
   assign quotient = mul[SHIFT +: WIDTH];

endmodule

`default_nettype wire

[design/battery_power_monitor_limiter_core.sv]
// Battery power monitor and current limiter, top level.
// Six register stages (s1 to s5, rsp); one word per cycle while rsp_tready keeps up,
// and each stage holds one word and frees when the next drains.
// Reset: synchronous; clears pipeline valids, power ring, ring sum, peaks and sets registers
// to their defaults. No clearing pass; words are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "battery_power_monitor_limiter_core_macros.svh"

module battery_power_monitor_limiter_core
   import bpml_pkg::*;
#(
   parameter int RING_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // volt_dv[13:0], cur_ma[34:14], charge[41:35], temp[50:42], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // volt[9:0], power[20:10], avg[31:21], peak_power[41:32], peak_volt[51:42],
   // peak_cur[61:52], over[62], limit[63]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CLOG_D = $clog2(RING_DEPTH);
   localparam int SUM_W  = POWER_W + CLOG_D;
   localparam int MAG_W  = PEAK_W + CLOG_D;

   // ---------------- configuration registers ----------------
   logic [9:0]        max_power_ff;
   logic [MAXW_W-1:0] max_power_w_ff;
   logic [6:0]        charge_low_ff;
   logic [6:0]        charge_crit_ff;
   logic [8:0]        temp_high_ff;
   logic [8:0]        temp_crit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_power_ff   <= MAX_POWER_RST;
         max_power_w_ff <= MAX_POWER_W_RST;
         charge_low_ff  <= CHARGE_LOW_RST;
         charge_crit_ff <= CHARGE_CRIT_RST;
         temp_high_ff   <= TEMP_HIGH_RST;
         temp_crit_ff   <= TEMP_CRIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MAX_POWER: begin
               max_power_ff   <= csr_wdata;
               max_power_w_ff <= MAXW_W'(csr_wdata * W_PER_KW);
            end
            CSR_CHARGE_LOW:  charge_low_ff  <= csr_wdata[6:0];
            CSR_CHARGE_CRIT: charge_crit_ff <= csr_wdata[6:0];
            CSR_TEMP_HIGH:   temp_high_ff   <= csr_wdata[8:0];
            CSR_TEMP_CRIT:   temp_crit_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, rsp_v_ff;
   logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv, rsp_adv;
   logic s1_ld, s2_ld, s3_ld, s4_ld, s5_ld, rsp_ld;

   assign rsp_adv = !rsp_v_ff || rsp_tready;
   assign s5_adv  = !s5_v_ff || rsp_adv;
   assign s4_adv  = !s4_v_ff || s5_adv;
   assign s3_adv  = !s3_v_ff || s4_adv;
   assign s2_adv  = !s2_v_ff || s3_adv;
   assign s1_adv  = !s1_v_ff || s2_adv;

   assign s1_ld  = s1_adv && req_tvalid;
   assign s2_ld  = s2_adv && s1_v_ff;
   assign s3_ld  = s3_adv && s2_v_ff;
   assign s4_ld  = s4_adv && s3_v_ff;
   assign s5_ld  = s5_adv && s4_v_ff;
   assign rsp_ld = rsp_adv && s5_v_ff;

   assign req_tready = s1_adv;
   assign rsp_tvalid = rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_adv)  s1_v_ff  <= req_tvalid;
         if (s2_adv)  s2_v_ff  <= s1_v_ff;
         if (s3_adv)  s3_v_ff  <= s2_v_ff;
         if (s4_adv)  s4_v_ff  <= s3_v_ff;
         if (s5_adv)  s5_v_ff  <= s4_v_ff;
         if (rsp_adv) rsp_v_ff <= s5_v_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   s1_type s1_ff, s1_in;

   always_comb begin
      s1_in.volt_dv = req_tdata[13:0];
      s1_in.cur_ma  = req_tdata[34:14];
      s1_in.charge  = req_tdata[41:35];
      s1_in.temp    = req_tdata[50:42];
   end

   always_ff @(posedge clock) begin
      if (s1_ld) s1_ff <= s1_in;
   end

   // ---------------- stage 2: whole volts/amps, derating ----------------
   s2_type                s2_ff, s2_in;
   logic [VOLT_DV_W-1:0]  volt_q;
   logic [CUR_MA_W-1:0]   cur_mag;
   logic [CUR_MA_W-1:0]   cur_q;
   logic [CUR_A_W-1:0]    cur_a;
   logic                  cur_neg;
   logic                  chg_crit, chg_low, tmp_crit, tmp_high;

   assign cur_neg = s1_ff.cur_ma[CUR_MA_W-1];
   assign cur_mag = cur_neg ? CUR_MA_W'(-s1_ff.cur_ma) : s1_ff.cur_ma;

   bpml_div_const #(.WIDTH(VOLT_DV_W), .DIVISOR(DV_PER_V)) u_div_volt (
      .dividend (s1_ff.volt_dv),
      .quotient (volt_q)
   );

   bpml_div_const #(.WIDTH(CUR_MA_W), .DIVISOR(MA_PER_A)) u_div_cur (
      .dividend (cur_mag),
      .quotient (cur_q)
   );

   assign chg_crit = s1_ff.charge < charge_crit_ff;
   assign chg_low  = s1_ff.charge < charge_low_ff;
   assign tmp_crit = $signed(s1_ff.temp) >= $signed(temp_crit_ff);
   assign tmp_high = $signed(s1_ff.temp) >= $signed(temp_high_ff);

   always_comb begin
      s2_in.volt   = (volt_q > VOLT_DV_W'(VOLT_MAX)) ? VOLT_MAX : volt_q[VOLT_W-1:0];
      cur_a        = (cur_q > CUR_MA_W'(CUR_MAX)) ? CUR_MAX : cur_q[CUR_A_W-1:0];
      s2_in.cur    = cur_neg ? CUR_A_W'(-cur_a) : cur_a;
      s2_in.zeroed = chg_crit || tmp_crit;
      // each active derate halves the allowed current
      s2_in.shift  = {1'b0, !chg_crit && chg_low} + {1'b0, !tmp_crit && tmp_high};
   end

   always_ff @(posedge clock) begin
      if (s2_ld) s2_ff <= s2_in;
   end

   // ---------------- stage 3: V * A ----------------
   s3_type                   s3_ff, s3_in;
   logic signed [PROD_W-1:0] volt_x, cur_x;

   assign volt_x = PROD_W'(s2_ff.volt);
   assign cur_x  = PROD_W'($signed(s2_ff.cur));

   always_comb begin
      s3_in.volt   = s2_ff.volt;
      s3_in.cur    = s2_ff.cur;
      s3_in.prod   = volt_x * cur_x;
      s3_in.zeroed = s2_ff.zeroed;
      s3_in.shift  = s2_ff.shift;
   end

   always_ff @(posedge clock) begin
      if (s3_ld) s3_ff <= s3_in;
   end

   // ---------------- stage 4: round to kW, current limit ----------------
   s4_type                  s4_ff, s4_in;
   logic                    prod_neg;
   logic [PROD_W-1:0]       prod_mag;
   logic [RND_W-1:0]        prod_rnd;
   logic [RND_W-1:0]        pw_q;
   logic [POWER_W-1:0]      pw_mag;
   logic signed [LIM_W-1:0] prod_sc;
   logic signed [LIM_W-1:0] lim_w;
   logic                    cur_pos;

   assign prod_neg = s3_ff.prod[PROD_W-1];
   assign prod_mag = prod_neg ? PROD_W'(-s3_ff.prod) : s3_ff.prod;
   assign prod_rnd = prod_mag[RND_W-1:0] + ROUND_HALF;

   bpml_div_const #(.WIDTH(RND_W), .DIVISOR(W_PER_KW)) u_div_power (
      .dividend (prod_rnd),
      .quotient (pw_q)
   );

   assign pw_mag  = pw_q[POWER_W-1:0];
   // scaling the product stands in for scaling the allowed current
   assign prod_sc = LIM_W'($signed(s3_ff.prod)) <<< s3_ff.shift;
   assign lim_w   = LIM_W'(max_power_w_ff);
   assign cur_pos = !s3_ff.cur[CUR_A_W-1] && (s3_ff.cur != '0);

   always_comb begin
      s4_in.volt  = s3_ff.volt;
      s4_in.cur   = s3_ff.cur;
      s4_in.power = prod_neg ? POWER_W'(-pw_mag) : pw_mag;
      if (s3_ff.zeroed) begin
         s4_in.limit = cur_pos;
      end else if (s3_ff.volt == '0) begin
         s4_in.limit = 1'b0;
      end else begin
         s4_in.limit = prod_sc > lim_w;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ld) s4_ff <= s4_in;
   end

   // ---------------- stage 5: power ring, running sum, peaks ----------------
   s5_type                    s5_ff, s5_in;
   logic signed [POWER_W-1:0] ring_ff [RING_DEPTH];
   logic signed [SUM_W-1:0]   ring_sum_ff, ring_sum_in;
   logic [PEAK_W-1:0]         peak_power_ff, peak_power_in;
   logic [PEAK_W-1:0]         peak_volt_ff, peak_volt_in;
   logic [PEAK_W-1:0]         peak_cur_ff, peak_cur_in;
   logic signed [SUM_W-1:0]   oldest_x, power_x;
   logic                      power_pos, cur_pos4;

   // the ring is a shift line; its last tap is the entry being replaced
   assign oldest_x    = SUM_W'(ring_ff[RING_DEPTH-1]);
   assign power_x     = SUM_W'($signed(s4_ff.power));
   assign ring_sum_in = ring_sum_ff - oldest_x + power_x;

   assign power_pos = !s4_ff.power[POWER_W-1];
   assign cur_pos4  = !s4_ff.cur[CUR_A_W-1];

   always_comb begin
      peak_power_in = peak_power_ff;
      if (power_pos && (s4_ff.power[PEAK_W-1:0] > peak_power_ff))
         peak_power_in = s4_ff.power[PEAK_W-1:0];
      peak_volt_in = (s4_ff.volt > peak_volt_ff) ? s4_ff.volt : peak_volt_ff;
      peak_cur_in  = peak_cur_ff;
      if (cur_pos4 && (s4_ff.cur[PEAK_W-1:0] > peak_cur_ff))
         peak_cur_in = s4_ff.cur[PEAK_W-1:0];
      s5_in.volt  = s4_ff.volt;
      s5_in.power = s4_ff.power;
      s5_in.limit = s4_ff.limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_sum_ff   <= '0;
         peak_power_ff <= '0;
         peak_volt_ff  <= '0;
         peak_cur_ff   <= '0;
      end else if (s5_ld) begin
         ring_sum_ff   <= ring_sum_in;
         peak_power_ff <= peak_power_in;
         peak_volt_ff  <= peak_volt_in;
         peak_cur_ff   <= peak_cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff[0] <= '0;
      end else if (s5_ld) begin
         ring_ff[0] <= $signed(s4_ff.power);
      end
   end

   for (genvar i = 1; i < RING_DEPTH; i++) begin : g_ring
      always_ff @(posedge clock) begin
         if (reset) begin
            ring_ff[i] <= '0;
         end else if (s5_ld) begin
            ring_ff[i] <= ring_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ld) s5_ff <= s5_in;
   end

   // ---------------- result register: mean, flags ----------------
   // state registers hold the snapshot of the word sitting in stage 5
   rsp_type              rsp_ff, rsp_in;
   logic                 sum_neg;
   logic [SUM_W-1:0]     sum_abs;
   logic [MAG_W-1:0]     avg_q;
   logic [POWER_W-1:0]   avg_mag;
   logic [POWER_W-1:0]   avg;

   assign sum_neg = ring_sum_ff[SUM_W-1];
   assign sum_abs = sum_neg ? SUM_W'(-ring_sum_ff) : ring_sum_ff;

   bpml_div_const #(.WIDTH(MAG_W), .DIVISOR(RING_DEPTH)) u_div_avg (
      .dividend (sum_abs[MAG_W-1:0]),
      .quotient (avg_q)
   );

   assign avg_mag = {1'b0, avg_q[PEAK_W-1:0]};
   assign avg     = sum_neg ? POWER_W'(-avg_mag) : avg_mag;

   always_comb begin
      rsp_in.volt       = s5_ff.volt;
      rsp_in.power      = s5_ff.power;
      rsp_in.avg        = avg;
      rsp_in.peak_power = peak_power_ff;
      rsp_in.peak_volt  = peak_volt_ff;
      rsp_in.peak_cur   = peak_cur_ff;
      rsp_in.over       = $signed({avg[POWER_W-1], avg}) > $signed({2'b00, max_power_ff});
      rsp_in.limit      = s5_ff.limit;
   end

   always_ff @(posedge clock) begin
      if (rsp_ld) rsp_ff <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

   // ---------------- assertions ----------------
   `BPML_ASSERT_NEXT(a_state_hold, !s5_ld, $stable(peak_power_ff) && $stable(ring_sum_ff))
   `BPML_ASSERT_NEXT(a_no_invent, rsp_adv && !s5_v_ff, !rsp_tvalid)
   `BPML_ASSERT_IMPL(a_over_pos, rsp_tvalid && rsp_ff.over, !rsp_ff.avg[POWER_W-1])

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the battery power monitor and current limiter core.
`timescale 1ns / 1ps

import bpml_pkg::*;

localparam int RING_DEPTH = 8;

// Tracks registers and monitor state, predicts each summary word, checks what comes back
class limiter_scoreboard;
   int max_power_kw;
   int charge_low_pct;
   int charge_crit_pct;
   int temp_high_c;
   int temp_crit_c;
   int power_ring[RING_DEPTH];
   int ring_slot;
   int ring_sum;
   int peak_power;
   int peak_volt;
   int peak_cur;
   rsp_type expected_summaries[$];
   int error_count;

   function new();
      max_power_kw    = MAX_POWER_RST;
      charge_low_pct  = CHARGE_LOW_RST;
      charge_crit_pct = CHARGE_CRIT_RST;
      temp_high_c     = $signed(TEMP_HIGH_RST);
      temp_crit_c     = $signed(TEMP_CRIT_RST);
      foreach (power_ring[k]) power_ring[k] = 0;
      ring_slot   = 0;
      ring_sum    = 0;
      peak_power  = 0;
      peak_volt   = 0;
      peak_cur    = 0;
      error_count = 0;
   endfunction

   // unknown indexes are dropped, as in the block
   function void set_register(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_MAX_POWER:   max_power_kw    = value;
         CSR_CHARGE_LOW:  charge_low_pct  = value[6:0];
         CSR_CHARGE_CRIT: charge_crit_pct = value[6:0];
         CSR_TEMP_HIGH:   temp_high_c     = $signed(value[8:0]);
         CSR_TEMP_CRIT:   temp_crit_c     = $signed(value[8:0]);
         default: ;
      endcase
   endfunction

   // one accepted sample word -> one expected summary word
   function void add_sample(logic [REQ_DATA_W-1:0] word);
      int volt, raw_ma, cur, charge, temp, prod, mag, power, avg;
      bit zeroed, limit;
      longint scale;
      rsp_type summary;
      volt   = word[13:0];
      volt   = volt / 10;
      raw_ma = $signed(word[34:14]);
      cur    = raw_ma / 1000;
      charge = word[41:35];
      temp   = $signed(word[50:42]);
      if (volt > 1000) volt = 1000;
      if (cur > 1000) cur = 1000;
      if (cur < -1000) cur = -1000;

      // power in kW, rounded half away from zero
      prod  = volt * cur;
      mag   = (prod < 0) ? -prod : prod;
      mag   = (mag + 500) / 1000;
      power = (prod < 0) ? -mag : mag;

      // new power enters the ring before the mean is taken
      ring_sum = ring_sum - power_ring[ring_slot] + power;
      power_ring[ring_slot] = power;
      ring_slot = (ring_slot + 1) % RING_DEPTH;
      avg = ring_sum / RING_DEPTH;

      if (power > peak_power) peak_power = power;
      if (volt > peak_volt) peak_volt = volt;
      if (cur > peak_cur) peak_cur = cur;

      // derating: critical levels zero the allowance, soft levels halve it
      zeroed = 1'b0;
      scale  = 1;
      if (charge < charge_crit_pct) zeroed = 1'b1;
      else if (charge < charge_low_pct) scale = scale * 2;
      if (temp >= temp_crit_c) zeroed = 1'b1;
      else if (temp >= temp_high_c) scale = scale * 2;

      if (zeroed) limit = (cur > 0);
      else if (volt == 0) limit = 1'b0;
      else limit = longint'(cur) * longint'(volt) * scale > longint'(max_power_kw) * 1000;

      summary.volt       = volt[9:0];
      summary.power      = power[10:0];
      summary.avg        = avg[10:0];
      summary.peak_power = peak_power[9:0];
      summary.peak_volt  = peak_volt[9:0];
      summary.peak_cur   = peak_cur[9:0];
      summary.over       = (avg > max_power_kw);
      summary.limit      = limit;
      expected_summaries.push_back(summary);
   endfunction

   function void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   function void check_summary(logic [RSP_DATA_W-1:0] word);
      rsp_type got, want;
      got = word;
      if (expected_summaries.size() == 0) begin
         $display("%0t: summary word %h arrived, expected none, actual %h",
                  $time, word, word);
         error_count++;
         return;
      end
      want = expected_summaries.pop_front();
      compare_field("voltage_v", want.volt, got.volt);
      compare_field("power_kw", $signed(want.power), $signed(got.power));
      compare_field("average_power_kw", $signed(want.avg), $signed(got.avg));
      compare_field("peak_power_kw", want.peak_power, got.peak_power);
      compare_field("peak_voltage_v", want.peak_volt, got.peak_volt);
      compare_field("peak_current_a", want.peak_cur, got.peak_cur);
      compare_field("over_average_flag", want.over, got.over);
      compare_field("current_limit_flag", want.limit, got.limit);
   endfunction

   function int pending();
      return expected_summaries.size();
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 100000;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_FIRST_UNUSED = 3'd5;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   limiter_scoreboard sb;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          gaps_on = 1'b1;
   rx_mode_type rx_mode = RX_ALWAYS;
   bit          hold_request = 1'b0;

   battery_power_monitor_limiter_core #(
      .RING_DEPTH(RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // cycle count and result check at the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_summary(rsp_tdata);
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // receiver: long hold-off on request, otherwise the current stall pattern
   initial begin : receiver
      int hold_left, run_left;
      bit ready_now;
      hold_left = 0;
      run_left  = 0;
      ready_now = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: begin
                  if (run_left == 0) begin
                     ready_now = !ready_now;
                     run_left = ready_now ? $urandom_range(1, 12) : $urandom_range(1, 5);
                  end
                  run_left--;
                  rsp_tready <= ready_now;
               end
            endcase
         end
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_sample(int dv, int ma, int chg, int tmp);
      return REQ_DATA_W'({tmp[8:0], chg[6:0], ma[20:0], dv[13:0]});
   endfunction

   // offer one word, with a random gap at the start of each burst when gaps_on is set
   task automatic push_word(input logic [REQ_DATA_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sb.add_sample(word);
   endtask

   // stop offering and wait for every summary to come back
   task automatic idle_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // unused upper bits get random values; the block must ignore them
   task automatic apply_settings(input int max_kw, input int low_pct, input int crit_pct,
                                 input int high_c, input int crit_c);
      logic [2:0] junk;
      junk = 3'($urandom_range(0, 7));
      write_reg(CSR_MAX_POWER, max_kw[9:0]);
      write_reg(CSR_CHARGE_LOW, {junk, low_pct[6:0]});
      write_reg(CSR_CHARGE_CRIT, {~junk, crit_pct[6:0]});
      write_reg(CSR_TEMP_HIGH, {junk[0], high_c[8:0]});
      write_reg(CSR_TEMP_CRIT, {~junk[0], crit_c[8:0]});
   endtask

   // random samples, biased toward range ends and the limit and derating edges
   task automatic run_random(input int count);
      int dv, ma, chg, tmp, volt, amps, sel;
      repeat (count) begin
         sel = $urandom_range(0, 9);
         if (sel < 2) dv = $urandom_range(0, 16383);
         else if (sel == 2) dv = $urandom_range(0, 15);
         else dv = $urandom_range(0, 10000);
         volt = dv / 10;
         if (volt > 1000) volt = 1000;

         case ($urandom_range(0, 4))
            0: begin
               ma = $urandom_range(0, 2097151);
               ma = ma - 1048576;
            end
            1: begin
               ma = $urandom_range(0, 2000000);
               ma = ma - 1000000;
            end
            2: begin
               ma = $urandom_range(0, 4000);
               ma = ma - 2000;
            end
            default: begin
               // just around the derated allowed current
               if (volt == 0) amps = $urandom_range(0, 3);
               else amps = sb.max_power_kw * 1000 / (volt << $urandom_range(0, 2));
               amps = amps + $urandom_range(0, 4) - 2;
               if (amps > 1000) amps = 1000;
               ma = amps * 1000 + $urandom_range(0, 999);
            end
         endcase

         if ($urandom_range(0, 1)) begin
            chg = $urandom_range(0, 127);
         end else begin
            chg = ($urandom_range(0, 1) ? sb.charge_low_pct : sb.charge_crit_pct)
                  + $urandom_range(0, 2) - 1;
            if (chg < 0) chg = 0;
            if (chg > 127) chg = 127;
         end

         sel = $urandom_range(0, 9);
         if (sel < 3) begin
            tmp = $urandom_range(0, 511);
            tmp = tmp - 256;
         end else if (sel < 7) begin
            tmp = $urandom_range(0, 190);
            tmp = tmp - 40;
         end else begin
            tmp = ($urandom_range(0, 1) ? sb.temp_high_c : sb.temp_crit_c)
                  + $urandom_range(0, 2) - 1;
            if (tmp < -256) tmp = -256;
            if (tmp > 255) tmp = 255;
         end

         push_word(pack_sample(dv, ma, chg, tmp));
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed samples under the reset settings
      rx_mode = RX_RANDOM;
      gaps_on = 1'b1;
      push_word(pack_sample(0, 0, 100, 25));
      push_word(pack_sample(16383, 1048575, 127, 49));      // voltage and current saturate
      push_word(pack_sample(10000, 1000000, 100, 25));
      push_word(pack_sample(10000, 1000000, 100, 25));      // mean still over the limit
      push_word(pack_sample(10000, -1048576, 0, -256));     // negative saturation, charge zero
      push_word(pack_sample(10, 500000, 100, 25));          // half kW rounds up
      push_word(pack_sample(10, -500999, 100, 25));         // half kW rounds away from zero
      push_word(pack_sample(10, 499000, 100, 25));
      push_word(pack_sample(19, -1999, 100, 25));           // current truncates toward zero
      push_word(pack_sample(9, 5000, 100, 25));             // zero volts, no limit
      push_word(pack_sample(9, 5000, 10, 25));              // zero volts but allowance zeroed
      push_word(pack_sample(4000, 200999, 100, 25));        // exactly at the limit
      push_word(pack_sample(4000, 201000, 100, 25));
      push_word(pack_sample(4000, 101000, 25, 25));         // low charge halves
      push_word(pack_sample(4000, 100000, 25, 25));
      push_word(pack_sample(4000, 101000, 100, 50));        // high temp halves
      push_word(pack_sample(4000, 50000, 25, 55));          // both halve
      push_word(pack_sample(4000, 51000, 25, 55));
      push_word(pack_sample(4000, 1000, 100, 60));          // critical temp
      push_word(pack_sample(4000, 0, 19, 25));              // critical charge, no current
      push_word(pack_sample(4000, -5000, 100, 150));        // zeroed, charging current
      push_word(pack_sample(10009, 999, 20, 59));           // on both thresholds
      idle_until_drained();

      // top of every range but the critical charge level
      apply_settings(1023, 127, 0, 255, 255);
      run_random(80);
      idle_until_drained();

      // bottom of every range: everything derated to zero
      apply_settings(0, 0, 0, -256, -256);
      rx_mode = RX_BURSTY;
      run_random(80);
      idle_until_drained();

      // no idling on either side, then a long receiver hold-off
      apply_settings(500, 50, 25, 40, 90);
      rx_mode = RX_ALWAYS;
      gaps_on = 1'b0;
      run_random(80);
      hold_request = 1'b1;
      run_random(40);
      idle_until_drained();

      apply_settings($urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 511), $urandom_range(0, 511));
      rx_mode = RX_BURSTY;
      gaps_on = 1'b1;
      run_random(80);
      idle_until_drained();

      apply_settings(1, 100, 100, -40, 150);
      rx_mode = RX_RANDOM;
      gaps_on = 1'b0;
      run_random(80);
      idle_until_drained();

      // back to defaults; writes to unused indexes must change nothing
      apply_settings(80, 30, 20, 50, 60);
      for (int a = CSR_FIRST_UNUSED; a < 2 ** CSR_ADDR_W; a++)
         write_reg(CSR_ADDR_W'(a), CSR_DATA_W'($urandom_range(0, 1023)));
      gaps_on = 1'b1;
      run_random(80);
      idle_until_drained();

      if (sb.error_count == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
